// ----- hdl/tbnpp_pkg.sv -----
package tbnpp_pkg;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
  localparam int unsigned HASH_SHIFT   = 13;

  typedef enum logic [2:0] {
    CFG_HASH_SEED     = 3'd0,
    CFG_TILE_SIZE     = 3'd1,
    CFG_BOUND_MIN_X   = 3'd2,
    CFG_BOUND_MIN_Y   = 3'd3,
    CFG_BOUND_MAX_X   = 3'd4,
    CFG_BOUND_MAX_Y   = 3'd5,
    CFG_POINTS_IN_USE = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_PLACE = 1'b1
  } kind_e;

  typedef struct packed {
    logic        [31:0] hash_seed;
    logic        [30:0] tile_size;
    logic signed [31:0] bound_min_x;
    logic signed [31:0] bound_min_y;
    logic signed [31:0] bound_max_x;
    logic signed [31:0] bound_max_y;
    logic        [12:0] points_in_use;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic               keep_pre;
    logic signed [15:0] tile_x;
    logic signed [15:0] tile_y;
    logic        [15:0] ux;
    logic        [15:0] uy;
  } qent_t;

endpackage

// ----- hdl/tbnpp_queue.sv -----
module tbnpp_queue (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  tbnpp_pkg::qent_t             push_data_i,
  input  logic                         pop_i,
  output tbnpp_pkg::qent_t             pop_data_o,
  output logic                         empty_o,
  output logic [tbnpp_pkg::QCNT_W-1:0] count_o
);

  tbnpp_pkg::qent_t                   store_q [tbnpp_pkg::QDEPTH];
  logic [tbnpp_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [tbnpp_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [tbnpp_pkg::QCNT_W-1:0]       count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = store_q[rd_ptr_q];
  assign empty_o    = (count_q == '0);
  assign count_o    = count_q;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (count_q != tbnpp_pkg::QCNT_W'(tbnpp_pkg::QDEPTH)) || pop_i)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");
  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue count lost a push");
`endif

endmodule

// ----- hdl/tbnpp_front.sv -----
module tbnpp_front #(
  parameter int unsigned TABLE_POINTS = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tbnpp_pkg::cfg_t              cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  tbnpp_pkg::kind_e             kind_i,
  input  logic signed [15:0]           tile_x_i,
  input  logic signed [15:0]           tile_y_i,
  input  logic [11:0]                  point_index_i,
  input  logic [15:0]                  local_x_i,
  input  logic [15:0]                  local_y_i,
  input  logic [tbnpp_pkg::QCNT_W-1:0] q_count_i,
  output logic                         push_o,
  output tbnpp_pkg::qent_t             push_data_o
);

  localparam int unsigned AW = $clog2(TABLE_POINTS);
  localparam int unsigned IW = (AW > 12) ? AW : 12;
  localparam int unsigned QCNT_W_L = tbnpp_pkg::QCNT_W + 1;

  logic [31:0]   table_q [TABLE_POINTS];
  logic [31:0]   rd_data_q;

  logic          accept;
  logic [IW-1:0] idx_ext;
  logic [AW-1:0] addr;
  logic          in_range;
  logic [12:0]   used_cnt;
  logic [QCNT_W_L-1:0] occupancy;

  logic                    s1_v_q, s2_v_q, s3_v_q;
  tbnpp_pkg::kind_e        s1_kind_q, s2_kind_q, s3_kind_q;
  logic                    s1_ok_q, s1_used_q;
  logic                    s2_keep_q, s3_keep_q;
  logic signed [15:0]      s1_tx_q, s1_ty_q, s2_tx_q, s2_ty_q, s3_tx_q, s3_ty_q;
  logic [31:0]             s2_point_q, s3_point_q;
  logic [31:0]             s2_px_q, s2_py_q;
  logic [31:0]             s3_hash_q;
  logic [31:0]             hash_pre;

  assign idx_ext  = IW'(point_index_i);
  assign addr     = idx_ext[AW-1:0];
  assign in_range = {1'b0, idx_ext} < (IW + 1)'(TABLE_POINTS);
  assign used_cnt = (cfg_i.points_in_use == '0) ? 13'd1 : cfg_i.points_in_use;

  assign occupancy  = QCNT_W_L'(q_count_i) + QCNT_W_L'(s1_v_q) + QCNT_W_L'(s2_v_q)
                    + QCNT_W_L'(s3_v_q);
  assign in_ready_o = occupancy < QCNT_W_L'(tbnpp_pkg::QDEPTH);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i) begin
    if (accept && kind_i == tbnpp_pkg::KIND_LOAD && in_range) begin
      table_q[addr] <= {local_y_i, local_x_i};
    end
    if (accept && kind_i == tbnpp_pkg::KIND_PLACE) begin
      rd_data_q <= table_q[addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      s1_v_q <= accept;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  assign hash_pre = cfg_i.hash_seed ^ s2_px_q ^ s2_py_q;

  always_ff @(posedge clk_i) begin
    s1_kind_q  <= kind_i;
    s1_ok_q    <= in_range;
    s1_used_q  <= {1'b0, point_index_i} < used_cnt;
    s1_tx_q    <= tile_x_i;
    s1_ty_q    <= tile_y_i;

    s2_kind_q  <= s1_kind_q;
    s2_keep_q  <= s1_ok_q && s1_used_q;
    s2_tx_q    <= s1_tx_q;
    s2_ty_q    <= s1_ty_q;
    s2_point_q <= s1_ok_q ? rd_data_q : 32'd0;
    s2_px_q    <= {{16{s1_tx_q[15]}}, s1_tx_q} * tbnpp_pkg::HASH_MUL_X;
    s2_py_q    <= {{16{s1_ty_q[15]}}, s1_ty_q} * tbnpp_pkg::HASH_MUL_Y;

    s3_kind_q  <= s2_kind_q;
    s3_keep_q  <= s2_keep_q;
    s3_tx_q    <= s2_tx_q;
    s3_ty_q    <= s2_ty_q;
    s3_point_q <= s2_point_q;
    s3_hash_q  <= (hash_pre ^ (hash_pre >> tbnpp_pkg::HASH_SHIFT))
                  * tbnpp_pkg::HASH_MUL_MIX;
  end

  assign push_o               = s3_v_q;
  assign push_data_o.kind     = s3_kind_q;
  assign push_data_o.keep_pre = s3_keep_q;
  assign push_data_o.tile_x   = s3_tx_q;
  assign push_data_o.tile_y   = s3_ty_q;
  assign push_data_o.ux       = s3_point_q[15:0] + s3_hash_q[15:0];
  assign push_data_o.uy       = s3_point_q[31:16] + s3_hash_q[31:16];

endmodule

// ----- hdl/tbnpp_back.sv -----
module tbnpp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tbnpp_pkg::cfg_t    cfg_i,
  input  logic               q_empty_i,
  input  tbnpp_pkg::qent_t   q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] world_x_o,
  output logic signed [31:0] world_y_o,
  output logic               keep_o
);

  logic                    advance;
  logic                    b1_v_q, b2_v_q, out_v_q;
  tbnpp_pkg::kind_e        b1_kind_q, b2_kind_q;
  logic                    b1_keep_q, b2_keep_q;
  logic signed [47:0]      b1_base_x_q, b1_base_y_q;
  logic [46:0]             b1_prod_x_q, b1_prod_y_q;
  logic signed [47:0]      b2_sum_x_q, b2_sum_y_q;
  logic signed [31:0]      sat_x, sat_y;
  logic                    ovf_x, ovf_y;
  logic signed [31:0]      out_x_q, out_y_q;
  logic                    out_keep_q;
  logic signed [31:0]      ts_s;

  assign ts_s    = $signed({1'b0, cfg_i.tile_size});
  assign advance = !out_v_q || out_ready_i;
  assign pop_o   = advance && !q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q  <= 1'b0;
      b2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      b1_v_q  <= pop_o;
      b2_v_q  <= b1_v_q;
      out_v_q <= b2_v_q;
    end
  end

  always_comb begin
    ovf_x = (b2_sum_x_q[47:31] != {17{b2_sum_x_q[47]}});
    ovf_y = (b2_sum_y_q[47:31] != {17{b2_sum_y_q[47]}});
    if (!ovf_x) begin
      sat_x = b2_sum_x_q[31:0];
    end else if (b2_sum_x_q[47]) begin
      sat_x = 32'sh8000_0000;
    end else begin
      sat_x = 32'sh7FFF_FFFF;
    end
    if (!ovf_y) begin
      sat_y = b2_sum_y_q[31:0];
    end else if (b2_sum_y_q[47]) begin
      sat_y = 32'sh8000_0000;
    end else begin
      sat_y = 32'sh7FFF_FFFF;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b1_kind_q   <= q_data_i.kind;
      b1_keep_q   <= q_data_i.keep_pre;
      b1_base_x_q <= 48'(q_data_i.tile_x) * 48'(ts_s);
      b1_base_y_q <= 48'(q_data_i.tile_y) * 48'(ts_s);
      b1_prod_x_q <= 47'(q_data_i.ux) * 47'(cfg_i.tile_size);
      b1_prod_y_q <= 47'(q_data_i.uy) * 47'(cfg_i.tile_size);

      b2_kind_q   <= b1_kind_q;
      b2_keep_q   <= b1_keep_q;
      b2_sum_x_q  <= b1_base_x_q + $signed({17'd0, b1_prod_x_q[46:16]});
      b2_sum_y_q  <= b1_base_y_q + $signed({17'd0, b1_prod_y_q[46:16]});

      if (b2_kind_q == tbnpp_pkg::KIND_LOAD) begin
        out_x_q    <= '0;
        out_y_q    <= '0;
        out_keep_q <= 1'b0;
      end else begin
        out_x_q    <= sat_x;
        out_y_q    <= sat_y;
        out_keep_q <= b2_keep_q && !ovf_x && !ovf_y
                      && sat_x >= cfg_i.bound_min_x && sat_x <= cfg_i.bound_max_x
                      && sat_y >= cfg_i.bound_min_y && sat_y <= cfg_i.bound_max_y;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign world_x_o   = out_x_q;
  assign world_y_o   = out_y_q;
  assign keep_o      = out_keep_q;

endmodule

// ----- hdl/tiled_blue_noise_point_placer_top.sv -----
// Tiled blue-noise point placer. Load requests (tuser = 0) write one tile point into the
// point table; place requests (tuser = 1) hash seed and tile into a per-tile offset, wrap
// the stored point by it and scale it by the tile size to a saturated signed Q16.16 world
// position, with keep set when it is in bounds, in use and unsaturated. Every request gives
// one result, loads give zeros. One request is taken per cycle while the queue and front stages
// have room; a result passes three front stages for table read and hash, the queue, and
// three back stages for scaling, saturation and bound checks. The eight-entry queue
// sets how many requests can be in flight while the output stalls. The table is undefined
// until loaded; configuration writes belong between runs, with no request in flight.
module tiled_blue_noise_point_placer_top #(
  parameter int unsigned TABLE_POINTS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tile_x[15:0], tile_y[31:16], point_index[43:32], local_x[59:44], local_y[75:60]
  input  logic [79:0] s_axis_tdata_i,
  // kind[0]
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // world_x[31:0], world_y[63:32]
  output logic [63:0] m_axis_tdata_o,
  // keep[0]
  output logic        m_axis_tuser_o
);

  tbnpp_pkg::cfg_t              cfg_q;
  logic                         push;
  tbnpp_pkg::qent_t             push_data;
  logic                         pop;
  tbnpp_pkg::qent_t             pop_data;
  logic                         q_empty;
  logic [tbnpp_pkg::QCNT_W-1:0] q_count;
  logic signed [31:0]           world_x, world_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hash_seed     <= 32'd0;
      cfg_q.tile_size     <= 31'd65536;
      cfg_q.bound_min_x   <= 32'sd0;
      cfg_q.bound_min_y   <= 32'sd0;
      cfg_q.bound_max_x   <= 32'sd65536;
      cfg_q.bound_max_y   <= 32'sd65536;
      cfg_q.points_in_use <= 13'd4096;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tbnpp_pkg::CFG_HASH_SEED:     cfg_q.hash_seed     <= cfg_wdata_i;
        tbnpp_pkg::CFG_TILE_SIZE:     cfg_q.tile_size     <= cfg_wdata_i[30:0];
        tbnpp_pkg::CFG_BOUND_MIN_X:   cfg_q.bound_min_x   <= cfg_wdata_i;
        tbnpp_pkg::CFG_BOUND_MIN_Y:   cfg_q.bound_min_y   <= cfg_wdata_i;
        tbnpp_pkg::CFG_BOUND_MAX_X:   cfg_q.bound_max_x   <= cfg_wdata_i;
        tbnpp_pkg::CFG_BOUND_MAX_Y:   cfg_q.bound_max_y   <= cfg_wdata_i;
        tbnpp_pkg::CFG_POINTS_IN_USE: cfg_q.points_in_use <= cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  tbnpp_front #(
    .TABLE_POINTS(TABLE_POINTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .kind_i       (tbnpp_pkg::kind_e'(s_axis_tuser_i)),
    .tile_x_i     (s_axis_tdata_i[15:0]),
    .tile_y_i     (s_axis_tdata_i[31:16]),
    .point_index_i(s_axis_tdata_i[43:32]),
    .local_x_i    (s_axis_tdata_i[59:44]),
    .local_y_i    (s_axis_tdata_i[75:60]),
    .q_count_i    (q_count),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  tbnpp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .pop_data_o (pop_data),
    .empty_o    (q_empty),
    .count_o    (q_count)
  );

  tbnpp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_data_i   (pop_data),
    .pop_o      (pop),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .world_x_o  (world_x),
    .world_y_o  (world_y),
    .keep_o     (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {world_y, world_x};

endmodule

// ----- tb/tb_tiled_blue_noise_point_placer_top.sv -----
`timescale 1ns / 100ps

module tb_tiled_blue_noise_point_placer_top;

  localparam int unsigned TBL_N = 4096;
  localparam logic [31:0] MIX_X = 32'd374761393;
  localparam logic [31:0] MIX_Y = 32'd668265263;
  localparam logic [31:0] MIX_H = 32'd1274126177;
  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;

  typedef struct {
    tbnpp_pkg::kind_e   kind;
    logic signed [15:0] tile_x;
    logic signed [15:0] tile_y;
    logic        [11:0] point_index;
    logic        [15:0] local_x;
    logic        [15:0] local_y;
    bit                 drain;
  } req_t;

  typedef struct {
    logic [31:0] world_x;
    logic [31:0] world_y;
    logic        keep;
  } pos_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  tiled_blue_noise_point_placer_top #(
    .TABLE_POINTS(TBL_N)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // predictor copy of the block's state and registers
  logic        [31:0] pt_mem [TBL_N];
  logic        [31:0] cfg_seed = 32'd0;
  logic        [30:0] cfg_tsize = 31'd65536;
  int                 cfg_min_x = 0;
  int                 cfg_min_y = 0;
  int                 cfg_max_x = 65536;
  int                 cfg_max_y = 65536;
  logic        [12:0] cfg_piu = 13'd4096;

  req_t request_q [$];
  pos_t due_pos_q [$];
  req_t cur_req;
  bit   gen_loaded [TBL_N];
  int   gen_list [$];

  int   n_queued = 0;
  int   n_accepted = 0;
  int   n_loads = 0;
  int   n_places = 0;
  int   n_kept = 0;
  int   n_sat = 0;
  int   n_settings = 0;
  int   n_errors = 0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   cyc = 0;
  bit   send;
  bit   rdy;
  pos_t got_pos;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint scale_axis(logic signed [15:0] tile, logic [15:0] u);
    longint base;
    logic [63:0] frac;
    base = longint'(tile) * longint'({33'd0, cfg_tsize});
    frac = ({48'd0, u} * {33'd0, cfg_tsize}) >> 16;
    return base + longint'(frac);
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > W_MAX) return 32'h7FFF_FFFF;
    if (v < W_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic pos_t place_point(req_t r);
    pos_t        o;
    logic [31:0] h;
    logic [31:0] p;
    logic [15:0] ux;
    logic [15:0] uy;
    longint      wx;
    longint      wy;
    bit          sat;
    int          used;
    o = '{32'd0, 32'd0, 1'b0};
    if (r.kind == tbnpp_pkg::KIND_LOAD) begin
      pt_mem[r.point_index] = {r.local_y, r.local_x};
      n_loads++;
      return o;
    end
    n_places++;
    p = pt_mem[r.point_index];
    h = cfg_seed ^ ({{16{r.tile_x[15]}}, r.tile_x} * MIX_X)
                 ^ ({{16{r.tile_y[15]}}, r.tile_y} * MIX_Y);
    h = (h ^ (h >> 13)) * MIX_H;
    ux = p[15:0] + h[15:0];
    uy = p[31:16] + h[31:16];
    wx = scale_axis(r.tile_x, ux);
    wy = scale_axis(r.tile_y, uy);
    sat = (wx > W_MAX) || (wx < W_MIN) || (wy > W_MAX) || (wy < W_MIN);
    o.world_x = clamp32(wx);
    o.world_y = clamp32(wy);
    used = (cfg_piu == 0) ? 1 : int'(cfg_piu);
    o.keep = (int'(r.point_index) < used) && !sat
             && ($signed(o.world_x) >= cfg_min_x) && ($signed(o.world_x) <= cfg_max_x)
             && ($signed(o.world_y) >= cfg_min_y) && ($signed(o.world_y) <= cfg_max_y);
    if (sat) n_sat++;
    if (o.keep) n_kept++;
    return o;
  endfunction

  // sender: bursts of requests separated by random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        due_pos_q.insert(due_pos_q.size(), place_point(cur_req));
        n_accepted++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        send = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0 &&
                     !(request_q[0].drain && due_pos_q.size() > 0)) begin
          cur_req = request_q.pop_front();
          send = 1'b1;
          s_axis_tdata_i <= {4'd0, cur_req.local_y, cur_req.local_x, cur_req.point_index,
                             cur_req.tile_y, cur_req.tile_x};
          s_axis_tuser_i <= cur_req.kind;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        s_axis_tvalid_i <= send;
      end
    end
  end

  // receiver: checks each result and rotates through four stall patterns
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      cyc++;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (due_pos_q.size() == 0) begin
          $error("result with nothing pending: world_x %h world_y %h keep %b",
                 m_axis_tdata_o[31:0], m_axis_tdata_o[63:32], m_axis_tuser_o);
          n_errors++;
        end else begin
          got_pos = due_pos_q.pop_front();
          if (m_axis_tdata_o[31:0] !== got_pos.world_x) begin
            $error("world_x: expected %h, actual %h", got_pos.world_x, m_axis_tdata_o[31:0]);
            n_errors++;
          end
          if (m_axis_tdata_o[63:32] !== got_pos.world_y) begin
            $error("world_y: expected %h, actual %h", got_pos.world_y, m_axis_tdata_o[63:32]);
            n_errors++;
          end
          if (m_axis_tuser_o !== got_pos.keep) begin
            $error("keep: expected %b, actual %b", got_pos.keep, m_axis_tuser_o);
            n_errors++;
          end
        end
      end
      case ((cyc / 256) % 4)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1);
        2: rdy = ($urandom_range(0, 7) == 0);
        default: rdy = (cyc % 5) != 0;
      endcase
      m_axis_tready_i <= rdy;
    end
  end

  task automatic push_req(tbnpp_pkg::kind_e kind, logic signed [15:0] tx,
                          logic signed [15:0] ty, logic [11:0] idx, logic [15:0] lx,
                          logic [15:0] ly, bit drain);
    req_t r;
    r = '{kind, tx, ty, idx, lx, ly, drain};
    if (kind == tbnpp_pkg::KIND_LOAD && !gen_loaded[idx]) begin
      gen_loaded[idx] = 1'b1;
      gen_list.insert(gen_list.size(), int'(idx));
    end
    request_q.insert(request_q.size(), r);
    n_queued++;
  endtask

  task automatic write_reg(tbnpp_pkg::cfg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      tbnpp_pkg::CFG_HASH_SEED:     cfg_seed = val;
      tbnpp_pkg::CFG_TILE_SIZE:     cfg_tsize = val[30:0];
      tbnpp_pkg::CFG_BOUND_MIN_X:   cfg_min_x = $signed(val);
      tbnpp_pkg::CFG_BOUND_MIN_Y:   cfg_min_y = $signed(val);
      tbnpp_pkg::CFG_BOUND_MAX_X:   cfg_max_x = $signed(val);
      tbnpp_pkg::CFG_BOUND_MAX_Y:   cfg_max_y = $signed(val);
      tbnpp_pkg::CFG_POINTS_IN_USE: cfg_piu = val[12:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_all(logic [31:0] seed, logic [31:0] ts, logic [31:0] min_x,
                           logic [31:0] min_y, logic [31:0] max_x, logic [31:0] max_y,
                           logic [31:0] piu);
    write_reg(tbnpp_pkg::CFG_HASH_SEED, seed);
    write_reg(tbnpp_pkg::CFG_TILE_SIZE, ts);
    write_reg(tbnpp_pkg::CFG_BOUND_MIN_X, min_x);
    write_reg(tbnpp_pkg::CFG_BOUND_MIN_Y, min_y);
    write_reg(tbnpp_pkg::CFG_BOUND_MAX_X, max_x);
    write_reg(tbnpp_pkg::CFG_BOUND_MAX_Y, max_y);
    write_reg(tbnpp_pkg::CFG_POINTS_IN_USE, piu);
    n_settings++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || due_pos_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_bound(longint tse, bit upper);
    if (upper)
      return clamp32(longint'($urandom_range(1, 4)) * tse - longint'($urandom_range(0, 65535)));
    return clamp32(-longint'($urandom_range(0, 3)) * tse + longint'($urandom_range(0, 65535)));
  endfunction

  task automatic random_setting();
    logic [31:0] seed;
    logic [31:0] ts;
    logic [31:0] piu;
    logic [31:0] b [4];
    longint      tse;
    case ($urandom_range(0, 2))
      0: seed = 32'd0;
      1: seed = 32'hFFFF_FFFF;
      default: seed = $urandom();
    endcase
    case ($urandom_range(0, 7))
      0: ts = 32'd1;
      1: ts = 32'h7FFF_FFFF;
      2: ts = 32'd0;
      3: ts = $urandom();
      default: ts = $urandom_range(1, 32'h4_0000);
    endcase
    tse = longint'(ts[30:0]);
    case ($urandom_range(0, 4))
      0: b = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
      1: b = '{$urandom(), $urandom(), $urandom(), $urandom()};
      default: b = '{pick_bound(tse, 0), pick_bound(tse, 0), pick_bound(tse, 1),
                     pick_bound(tse, 1)};
    endcase
    case ($urandom_range(0, 7))
      0: piu = 32'd1;
      1: piu = 32'd4096;
      2: piu = 32'd0;
      3: piu = 32'd8191;
      4: piu = $urandom();
      default: piu = $urandom_range(1, 4096);
    endcase
    write_all(seed, ts, b[0], b[1], b[2], b[3], piu);
  endtask

  initial begin
    #6_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset: field extremes and alternating bit patterns
    push_req(tbnpp_pkg::KIND_LOAD, 0, 0, 12'd0, 16'h0000, 16'h0000, 0);
    push_req(tbnpp_pkg::KIND_LOAD, 0, 0, 12'd4095, 16'hFFFF, 16'hFFFF, 0);
    push_req(tbnpp_pkg::KIND_LOAD, 0, 0, 12'd1, 16'hFFFF, 16'h0000, 0);
    push_req(tbnpp_pkg::KIND_LOAD, 0, 0, 12'd2, 16'h0000, 16'hFFFF, 0);
    push_req(tbnpp_pkg::KIND_LOAD, 16'h5555, 16'hAAAA, 12'h555, 16'h5555, 16'hAAAA, 0);
    push_req(tbnpp_pkg::KIND_LOAD, 16'hAAAA, 16'h5555, 12'hAAA, 16'hAAAA, 16'h5555, 0);
    push_req(tbnpp_pkg::KIND_PLACE, 0, 0, 12'd0, 16'hFFFF, 16'hFFFF, 0);
    push_req(tbnpp_pkg::KIND_PLACE, 16'sh8000, 16'sh7FFF, 12'd4095, 0, 0, 0);
    push_req(tbnpp_pkg::KIND_PLACE, 16'sh7FFF, 16'sh8000, 12'd1, 0, 0, 0);
    push_req(tbnpp_pkg::KIND_PLACE, -1, -1, 12'd2, 0, 0, 0);
    push_req(tbnpp_pkg::KIND_PLACE, 0, 0, 12'hAAA, 0, 0, 0);
    wait_drained();

    // zero tile size and zero points in use
    write_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    push_req(tbnpp_pkg::KIND_PLACE, 5, -5, 12'd0, 0, 0, 0);
    push_req(tbnpp_pkg::KIND_PLACE, 0, 0, 12'd1, 0, 0, 1);
    wait_drained();

    // largest tile size: saturation at both ends
    write_all(32'h1234_5678, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd8191);
    push_req(tbnpp_pkg::KIND_PLACE, 16'sh7FFF, 16'sh7FFF, 12'd4095, 0, 0, 0);
    push_req(tbnpp_pkg::KIND_PLACE, 16'sh8000, 16'sh8000, 12'd0, 0, 0, 0);
    push_req(tbnpp_pkg::KIND_PLACE, 0, 0, 12'd1, 0, 0, 0);
    push_req(tbnpp_pkg::KIND_PLACE, -1, 0, 12'd2, 0, 0, 0);
    wait_drained();

    // smallest tile size, then load followed at once by a place of that entry
    write_all(32'h0, 32'd1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'd4096);
    push_req(tbnpp_pkg::KIND_PLACE, 16'sh7FFF, 16'sh8000, 12'h555, 0, 0, 0);
    push_req(tbnpp_pkg::KIND_PLACE, 0, 0, 12'hAAA, 0, 0, 0);
    push_req(tbnpp_pkg::KIND_LOAD, 0, 0, 12'd7, 16'h1234, 16'h4321, 0);
    push_req(tbnpp_pkg::KIND_PLACE, 0, 0, 12'd7, 0, 0, 0);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      random_setting();
      for (int i = 0; i < 190; i++) begin
        if ($urandom_range(0, 99) < 25) begin
          push_req(tbnpp_pkg::KIND_LOAD, 16'($urandom()), 16'($urandom()),
                   12'($urandom()), 16'($urandom()), 16'($urandom()), i == 60);
        end else begin
          if ($urandom_range(0, 4) == 0) begin
            tx = 16'($urandom());
            ty = 16'($urandom());
          end else begin
            tx = 16'($urandom_range(0, 8)) - 16'd4;
            ty = 16'($urandom_range(0, 8)) - 16'd4;
          end
          push_req(tbnpp_pkg::KIND_PLACE, tx, ty,
                   12'(gen_list[$urandom_range(0, gen_list.size() - 1)]),
                   16'($urandom()), 16'($urandom()), i == 60);
        end
      end
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("summary: %0d loads and %0d places over %0d register settings", n_loads,
             n_places, n_settings);
    $display("summary: %0d points kept, %0d saturated", n_kept, n_sat);
    if (n_errors == 0 && due_pos_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/tbnpp_pkg.sv
hdl/tbnpp_queue.sv
hdl/tbnpp_front.sv
hdl/tbnpp_back.sv
hdl/tiled_blue_noise_point_placer_top.sv
tb/tb_tiled_blue_noise_point_placer_top.sv
